/* hdl/t80_pkg.sv */
// ----------------------------------------------------------------------------
// t80_pkg
// Shared types, constants and helpers of the small 8080-subset core.
// ----------------------------------------------------------------------------
package t80_pkg;

   localparam int unsigned DEF_MEM_DEPTH = 65536;
   localparam int unsigned GP_COUNT      = 6;

   // Word operation codes on the request channel.
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_EXEC  = 2'd2;

   // Status codes on the response channel.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_HALTED  = 2'd1;
   localparam logic [1:0] STAT_UNKNOWN = 2'd2;

   // Register file indexes (B, C, D, E, H, L).
   localparam logic [2:0] REG_H = 3'd4;
   localparam logic [2:0] REG_L = 3'd5;

   // Instruction opcodes.
   localparam logic [7:0] OPC_NOP      = 8'h00;
   localparam logic [7:0] OPC_LD_B_N   = 8'h06;
   localparam logic [7:0] OPC_LD_C_N   = 8'h0E;
   localparam logic [7:0] OPC_LD_D_N   = 8'h16;
   localparam logic [7:0] OPC_LD_E_N   = 8'h1E;
   localparam logic [7:0] OPC_INC_HL   = 8'h23;
   localparam logic [7:0] OPC_LD_H_N   = 8'h26;
   localparam logic [7:0] OPC_DEC_HL   = 8'h2B;
   localparam logic [7:0] OPC_LD_L_N   = 8'h2E;
   localparam logic [7:0] OPC_LD_A_N   = 8'h3E;
   localparam logic [7:0] OPC_HALT     = 8'h76;
   localparam logic [7:0] OPC_LD_HL_A  = 8'h77;
   localparam logic [7:0] OPC_LD_A_B   = 8'h78;
   localparam logic [7:0] OPC_LD_A_C   = 8'h79;
   localparam logic [7:0] OPC_LD_A_D   = 8'h7A;
   localparam logic [7:0] OPC_LD_A_E   = 8'h7B;
   localparam logic [7:0] OPC_LD_A_H   = 8'h7C;
   localparam logic [7:0] OPC_LD_A_L   = 8'h7D;
   localparam logic [7:0] OPC_LD_A_HL  = 8'h7E;
   localparam logic [7:0] OPC_LD_A_A   = 8'h7F;
   localparam logic [7:0] OPC_ADD_A_B  = 8'h80;
   localparam logic [7:0] OPC_ADD_A_C  = 8'h81;
   localparam logic [7:0] OPC_ADD_A_D  = 8'h82;
   localparam logic [7:0] OPC_ADD_A_E  = 8'h83;
   localparam logic [7:0] OPC_ADD_A_H  = 8'h84;
   localparam logic [7:0] OPC_ADD_A_L  = 8'h85;
   localparam logic [7:0] OPC_ADD_A_HL = 8'h86;
   localparam logic [7:0] OPC_JP       = 8'hC3;

   // One access to the byte memory.
   typedef struct packed {
      logic        en;
      logic        we;
      logic [15:0] addr;
      logic [7:0]  wdata;
   } mem_req_type;

   // One finished response word.
   typedef struct packed {
      logic [7:0]  rdata;
      logic [15:0] pc;
      logic [7:0]  acc;
      logic [1:0]  status;
   } res_type;

   // Reduces a 16-bit address modulo the memory depth. For a depth of at
   // least 256 the quotient fits in eight bits and eight compare-and-subtract
   // steps are enough.
   function automatic logic [15:0] mem_index(input logic [15:0] a,
                                             input int unsigned depth);
      logic [23:0] v;
      logic [23:0] lim;
      v = {8'd0, a};
      for (int k = 7; k >= 0; k--) begin
         lim = 24'(depth) << k;
         if (v >= lim) begin
            v = v - lim;
         end
      end
      return v[15:0];
   endfunction

endpackage

/* hdl/t80_ifs.sv */
// ----------------------------------------------------------------------------
// t80 channel interfaces
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface t80_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] addr;
   logic [7:0]  wdata;

   modport source (output valid, op, addr, wdata, input ready);
   modport sink   (input valid, op, addr, wdata, output ready);
endinterface

interface t80_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rdata;
   logic [15:0] pc_out;
   logic [7:0]  acc_out;
   logic [1:0]  status;

   modport source (output valid, rdata, pc_out, acc_out, status, input ready);
   modport sink   (input valid, rdata, pc_out, acc_out, status, output ready);
endinterface

/* hdl/tiny_8080_subset_core.sv */
// ----------------------------------------------------------------------------
// tiny_8080_subset_core
// Small 8-bit CPU core that owns a byte memory and serves write, read and
// single-step words.
//
//   Channel   Dir   Payload                           Meaning
//   req_bus   in    op, addr, wdata                   write, read or execute
//   rsp_bus   out   rdata, pc_out, acc_out, status    one response per word
//
// A write word, an op code 3 word and an execute word while halted go
// straight to the done state; a read word passes S_RDATA first. An
// execute word fetches its opcode in S_OPC; LD r,n, LD A,(HL), ADD A,(HL)
// and JP nn then pass S_OPND, S_HLDATA, or S_JPLO and S_JPHI; all memory
// accesses share the single memory port. After reset the memory is swept
// to zero, one byte per cycle; req_bus.ready stays low during the sweep.
// A stalled response waits in the output register while the next word is
// already accepted and worked on.
// ----------------------------------------------------------------------------
module tiny_8080_subset_core #(
   parameter int unsigned MEM_DEPTH = t80_pkg::DEF_MEM_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   t80_req_if.sink    req_bus,
   t80_rsp_if.source  rsp_bus
);
   import t80_pkg::*;

   mem_req_type mem_req;
   logic [7:0]  mem_rdata;
   logic        clr_busy;
   logic        res_valid;
   logic        res_ready;
   res_type     res;

   logic        out_valid_ff, out_valid_in;
   res_type     out_ff;

   // The memory holds all program and data bytes; the sequencer reads and
   // writes it, one access per cycle.
   t80_mem #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata),
      .clr_busy  (clr_busy)
   );

   t80_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .clr_busy  (clr_busy),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // The output register takes a new response when it is empty or when its
   // current word leaves in the same cycle.
   assign res_ready = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_ff <= res;
      end
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.rdata   = out_ff.rdata;
   assign rsp_bus.pc_out  = out_ff.pc;
   assign rsp_bus.acc_out = out_ff.acc;
   assign rsp_bus.status  = out_ff.status;

endmodule

/* hdl/t80_mem.sv */
// ----------------------------------------------------------------------------
// t80_mem
// Single-port byte memory with registered read data and a zeroing sweep
// after reset.
// ----------------------------------------------------------------------------
module t80_mem #(
   parameter int unsigned MEM_DEPTH = t80_pkg::DEF_MEM_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  t80_pkg::mem_req_type  mem_req,
   output logic [7:0]            mem_rdata,
   output logic                  clr_busy
);
   import t80_pkg::*;

   localparam int unsigned AW = $clog2(MEM_DEPTH);

   logic [7:0]    ram [MEM_DEPTH];
   logic [7:0]    rdata_ff;
   logic          clr_busy_ff;
   logic          clr_busy_in;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;
   logic [15:0]   req_index;
   logic [AW-1:0] idx;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   assign req_index = mem_index(mem_req.addr, MEM_DEPTH);
   assign idx       = req_index[AW-1:0];

   // The sweep owns the write port until every entry holds zero.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == AW'(MEM_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   assign wr_en   = clr_busy_ff || (mem_req.en && mem_req.we);
   assign wr_addr = clr_busy_ff ? clr_addr_ff : idx;
   assign wr_data = clr_busy_ff ? 8'd0 : mem_req.wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram[wr_addr] <= wr_data;
      end
      if (mem_req.en && !mem_req.we && !clr_busy_ff) begin
         rdata_ff <= ram[idx];
      end
   end

   assign mem_rdata = rdata_ff;
   assign clr_busy  = clr_busy_ff;

endmodule

/* hdl/t80_seq.sv */
// ----------------------------------------------------------------------------
// t80_seq
// Instruction sequencer: holds the CPU registers and steps each request word
// through its memory accesses.
// ----------------------------------------------------------------------------
module t80_seq (
   input  logic                  clock,
   input  logic                  reset,
   t80_req_if.sink               req,
   input  logic                  clr_busy,
   output t80_pkg::mem_req_type  mem_req,
   input  logic [7:0]            mem_rdata,
   output logic                  res_valid,
   input  logic                  res_ready,
   output t80_pkg::res_type      res
);
   import t80_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RDATA  = 3'd1;
   localparam logic [2:0] S_OPC    = 3'd2;
   localparam logic [2:0] S_OPND   = 3'd3;
   localparam logic [2:0] S_HLDATA = 3'd4;
   localparam logic [2:0] S_JPLO   = 3'd5;
   localparam logic [2:0] S_JPHI   = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [15:0] pc_ff, pc_in;
   logic [7:0]  a_ff, a_in;
   logic [7:0]  gp_ff [GP_COUNT];
   logic [7:0]  gp_in [GP_COUNT];
   logic        halted_ff, halted_in;
   logic [7:0]  opc_ff, opc_in;
   logic [7:0]  lo_ff, lo_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic [1:0]  status_ff, status_in;

   logic        can_take;
   logic [15:0] hl;
   logic [15:0] hl_next;
   logic [7:0]  opc;

   assign hl  = {gp_ff[REG_H], gp_ff[REG_L]};
   assign opc = mem_rdata;

   assign can_take  = !clr_busy && (state_ff == S_IDLE || (state_ff == S_DONE && res_ready));
   assign req.ready = can_take;
   assign res_valid = (state_ff == S_DONE);

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      a_in      = a_ff;
      gp_in     = gp_ff;
      halted_in = halted_ff;
      opc_in    = opc_ff;
      lo_in     = lo_ff;
      rdata_in  = rdata_ff;
      status_in = status_ff;
      hl_next   = hl;
      mem_req   = '0;

      unique case (state_ff)
         S_IDLE: begin
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         S_RDATA: begin
            rdata_in = mem_rdata;
            state_in = S_DONE;
         end
         S_OPC: begin
            opc_in   = opc;
            state_in = S_DONE;
            pc_in    = pc_ff + 16'd1;
            unique case (opc) inside
               OPC_NOP, OPC_LD_A_A: begin
               end
               OPC_INC_HL: begin
                  hl_next = hl + 16'd1;
               end
               OPC_DEC_HL: begin
                  hl_next = hl - 16'd1;
               end
               OPC_LD_A_N, OPC_LD_B_N, OPC_LD_C_N, OPC_LD_D_N, OPC_LD_E_N,
               OPC_LD_H_N, OPC_LD_L_N, OPC_JP: begin
                  pc_in        = pc_ff;
                  mem_req.en   = 1'b1;
                  mem_req.addr = pc_ff + 16'd1;
                  state_in     = (opc == OPC_JP) ? S_JPLO : S_OPND;
               end
               OPC_LD_HL_A: begin
                  mem_req.en    = 1'b1;
                  mem_req.we    = 1'b1;
                  mem_req.addr  = hl;
                  mem_req.wdata = a_ff;
               end
               OPC_LD_A_HL, OPC_ADD_A_HL: begin
                  pc_in        = pc_ff;
                  mem_req.en   = 1'b1;
                  mem_req.addr = hl;
                  state_in     = S_HLDATA;
               end
               OPC_LD_A_B, OPC_LD_A_C, OPC_LD_A_D, OPC_LD_A_E,
               OPC_LD_A_H, OPC_LD_A_L: begin
                  a_in = gp_ff[opc[2:0]];
               end
               OPC_ADD_A_B, OPC_ADD_A_C, OPC_ADD_A_D, OPC_ADD_A_E,
               OPC_ADD_A_H, OPC_ADD_A_L: begin
                  a_in = a_ff + gp_ff[opc[2:0]];
               end
               OPC_HALT: begin
                  pc_in     = pc_ff;
                  halted_in = 1'b1;
                  status_in = STAT_HALTED;
               end
               default: begin
                  status_in = STAT_UNKNOWN;
               end
            endcase
            gp_in[REG_H] = hl_next[15:8];
            gp_in[REG_L] = hl_next[7:0];
         end
         S_OPND: begin
            if (opc_ff == OPC_LD_A_N) begin
               a_in = mem_rdata;
            end else begin
               gp_in[opc_ff[5:3]] = mem_rdata;
            end
            pc_in    = pc_ff + 16'd2;
            state_in = S_DONE;
         end
         S_HLDATA: begin
            a_in     = (opc_ff == OPC_LD_A_HL) ? mem_rdata : a_ff + mem_rdata;
            pc_in    = pc_ff + 16'd1;
            state_in = S_DONE;
         end
         S_JPLO: begin
            lo_in        = mem_rdata;
            mem_req.en   = 1'b1;
            mem_req.addr = pc_ff + 16'd2;
            state_in     = S_JPHI;
         end
         S_JPHI: begin
            pc_in    = {mem_rdata, lo_ff};
            state_in = S_DONE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A new word may enter in the same cycle that the previous result leaves.
      if (req.valid && can_take) begin
         rdata_in  = 8'd0;
         status_in = STAT_OK;
         state_in  = S_DONE;
         unique case (req.op)
            OP_WRITE: begin
               mem_req.en    = 1'b1;
               mem_req.we    = 1'b1;
               mem_req.addr  = req.addr;
               mem_req.wdata = req.wdata;
            end
            OP_READ: begin
               mem_req.en   = 1'b1;
               mem_req.addr = req.addr;
               state_in     = S_RDATA;
            end
            OP_EXEC: begin
               if (halted_ff) begin
                  status_in = STAT_HALTED;
               end else begin
                  mem_req.en   = 1'b1;
                  mem_req.addr = pc_ff;
                  state_in     = S_OPC;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pc_ff     <= '0;
         a_ff      <= '0;
         halted_ff <= 1'b0;
         for (int i = 0; i < GP_COUNT; i++) begin
            gp_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         a_ff      <= a_in;
         halted_ff <= halted_in;
         gp_ff     <= gp_in;
      end
   end

   always_ff @(posedge clock) begin
      opc_ff    <= opc_in;
      lo_ff     <= lo_in;
      rdata_ff  <= rdata_in;
      status_ff <= status_in;
   end

   assign res.rdata  = rdata_ff;
   assign res.pc     = pc_ff;
   assign res.acc    = a_ff;
   assign res.status = status_ff;

endmodule

/* sim/tiny_8080_subset_core_test.sv */
// ----------------------------------------------------------------------------
// tiny_8080_subset_core_test
// Self-checking bench for the 8080-subset core. A queue of request words feeds
// a clocked driver, and a clocked monitor checks every response word against
// a shadow copy of the core. The stimulus starts with a short directed program
// that covers the edges. Random programs are then written into memory and
// stepped through, mixed with stray words. A halt sequence closes the run.
// ----------------------------------------------------------------------------
module tiny_8080_subset_core_test;
   import t80_pkg::*;

   localparam int unsigned MEM_DEPTH = DEF_MEM_DEPTH;

   // The package names three word operations. The fourth encoding is a no-op.
   localparam logic [1:0] OP_NONE = 2'd3;

   // The request side stops generating once roughly this many words are queued.
   localparam int ITEM_TARGET = 1425;

   // The watchdog counts cycles in which neither channel moves a word. The
   // memory sweep after reset alone is one long such stretch, so the limit
   // is scaled with MEM_DEPTH to lie well beyond it.
   localparam int IDLE_LIMIT = 4 * MEM_DEPTH + 1000;

   // The instructions that random programs are built from. JP is kept apart
   // because it needs target selection. HALT is kept for the closing sequence.
   localparam int NUM_BODY_OPS = 26;
   localparam logic [7:0] BODY_OPS [NUM_BODY_OPS] = '{
      OPC_NOP, OPC_LD_B_N, OPC_LD_C_N, OPC_LD_D_N, OPC_LD_E_N, OPC_LD_H_N,
      OPC_LD_L_N, OPC_LD_A_N, OPC_INC_HL, OPC_DEC_HL, OPC_LD_HL_A,
      OPC_LD_A_HL, OPC_LD_A_B, OPC_LD_A_C, OPC_LD_A_D, OPC_LD_A_E,
      OPC_LD_A_H, OPC_LD_A_L, OPC_LD_A_A, OPC_ADD_A_B, OPC_ADD_A_C,
      OPC_ADD_A_D, OPC_ADD_A_E, OPC_ADD_A_H, OPC_ADD_A_L, OPC_ADD_A_HL
   };

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] addr;
      logic [7:0]  wdata;
   } req_word_type;

   logic clock = 1'b0;
   logic reset;

   t80_req_if req_bus ();
   t80_rsp_if rsp_bus ();

   tiny_8080_subset_core #(
      .MEM_DEPTH(MEM_DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #4 clock = ~clock;

   // -------------------------------------------------------------------------
   // Shadow copy of the core. It is updated once per accepted request word.
   // -------------------------------------------------------------------------
   logic [7:0]  core_mem [MEM_DEPTH];
   logic [7:0]  core_a;
   logic [7:0]  core_gp [GP_COUNT];
   logic [15:0] core_pc;
   logic        core_halted;

   req_word_type pending_words [$];
   res_type      expected_rsp_q [$];

   int          sent_count;
   int          error_count;
   int          rsp_index;
   int          idle_cycles;
   int          gap_left;
   int          stall_left;
   bit          req_taken;
   bit          rsp_taken;
   bit          calm;

   // Every memory address is taken modulo the depth. This includes the
   // operand fetches at PC+1 and PC+2, which have already wrapped at 16 bits.
   function automatic int unsigned mem_slot(logic [15:0] a);
      return int'(a) % MEM_DEPTH;
   endfunction

   // Runs one instruction at the program counter and returns its status.
   function automatic logic [1:0] exec_instruction();
      logic [7:0]  opc;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [15:0] hl;
      logic [15:0] next_pc;
      logic [1:0]  st;
      if (core_halted) begin
         return STAT_HALTED;
      end
      opc     = core_mem[mem_slot(core_pc)];
      b1      = core_mem[mem_slot(core_pc + 16'd1)];
      b2      = core_mem[mem_slot(core_pc + 16'd2)];
      hl      = {core_gp[REG_H], core_gp[REG_L]};
      next_pc = core_pc + 16'd1;
      st      = STAT_OK;
      case (opc)
         OPC_NOP, OPC_LD_A_A: begin
         end
         OPC_INC_HL: begin
            {core_gp[REG_H], core_gp[REG_L]} = hl + 16'd1;
         end
         OPC_DEC_HL: begin
            {core_gp[REG_H], core_gp[REG_L]} = hl - 16'd1;
         end
         OPC_LD_A_N: begin
            core_a  = b1;
            next_pc = core_pc + 16'd2;
         end
         OPC_LD_B_N, OPC_LD_C_N, OPC_LD_D_N, OPC_LD_E_N, OPC_LD_H_N,
         OPC_LD_L_N: begin
            core_gp[opc[5:3]] = b1;
            next_pc           = core_pc + 16'd2;
         end
         OPC_LD_HL_A: begin
            core_mem[mem_slot(hl)] = core_a;
         end
         OPC_LD_A_HL: begin
            core_a = core_mem[mem_slot(hl)];
         end
         OPC_LD_A_B, OPC_LD_A_C, OPC_LD_A_D, OPC_LD_A_E, OPC_LD_A_H,
         OPC_LD_A_L: begin
            core_a = core_gp[opc[2:0]];
         end
         OPC_ADD_A_B, OPC_ADD_A_C, OPC_ADD_A_D, OPC_ADD_A_E, OPC_ADD_A_H,
         OPC_ADD_A_L: begin
            core_a = core_a + core_gp[opc[2:0]];
         end
         OPC_ADD_A_HL: begin
            core_a = core_a + core_mem[mem_slot(hl)];
         end
         OPC_JP: begin
            next_pc = {b2, b1};
         end
         OPC_HALT: begin
            // The program counter stays on the HALT byte.
            core_halted = 1'b1;
            next_pc     = core_pc;
            st          = STAT_HALTED;
         end
         default: begin
            st = STAT_UNKNOWN;
         end
      endcase
      core_pc = next_pc;
      return st;
   endfunction

   // Applies one request word to the shadow core and returns the response
   // word that it must produce.
   function automatic res_type step_core(logic [1:0] op, logic [15:0] addr,
                                         logic [7:0] wdata);
      res_type r;
      r = '0;
      case (op)
         OP_WRITE: core_mem[mem_slot(addr)] = wdata;
         OP_READ:  r.rdata = core_mem[mem_slot(addr)];
         OP_EXEC:  r.status = exec_instruction();
         default: begin
         end
      endcase
      r.pc  = core_pc;
      r.acc = core_a;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers.
   // -------------------------------------------------------------------------
   function automatic bit is_known_opcode(logic [7:0] v);
      if (v == OPC_JP || v == OPC_HALT) begin
         return 1'b1;
      end
      foreach (BODY_OPS[k]) begin
         if (BODY_OPS[k] == v) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [7:0] unknown_opcode();
      logic [7:0] v;
      do begin
         v = 8'($urandom_range(0, 255));
      end while (is_known_opcode(v));
      return v;
   endfunction

   function automatic int instr_length(logic [7:0] opc);
      case (opc)
         OPC_LD_B_N, OPC_LD_C_N, OPC_LD_D_N, OPC_LD_E_N, OPC_LD_H_N,
         OPC_LD_L_N, OPC_LD_A_N: return 2;
         OPC_JP:                 return 3;
         default:                return 1;
      endcase
   endfunction

   // In calm stretches both sides run back to back.
   function automatic int draw_wait();
      return calm ? 0 : int'($urandom_range(0, 3));
   endfunction

   task automatic send(logic [1:0] op, logic [15:0] addr, logic [7:0] wdata);
      req_word_type w;
      w.op    = op;
      w.addr  = addr;
      w.wdata = wdata;
      pending_words.push_back(w);
      sent_count++;
   endtask

   // Returns once every queued word has been accepted. The shadow program
   // counter is current from that point on.
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_words.size() != 0 || req_bus.valid);
   endtask

   // Holds the sender back until every expected response has come.
   task automatic settle();
      wait_idle();
      while (expected_rsp_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Writes a short random program at the current program counter and steps
   // through it. Some programs are stepped too few or too many times.
   task automatic run_program();
      logic [15:0] at;
      logic [7:0]  opc;
      logic [7:0]  b1;
      logic [7:0]  b2;
      int          n;
      int          len;
      int          steps;
      int          pick;
      wait_idle();
      at = core_pc;
      n  = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            opc = unknown_opcode();
         end else if (pick <= 2) begin
            opc = OPC_JP;
         end else begin
            opc = BODY_OPS[$urandom_range(0, NUM_BODY_OPS - 1)];
         end
         b1 = 8'($urandom);
         b2 = 8'($urandom);
         // Pointing H at the code page makes HL accesses meet program bytes.
         if (opc == OPC_LD_H_N && $urandom_range(0, 1) == 0) begin
            b1 = at[15:8];
         end
         // Jumps favor both ends of the address space so that the operand
         // fetches wrap.
         if (opc == OPC_JP) begin
            case ($urandom_range(0, 2))
               0:       {b2, b1} = 16'hFFF0 + 16'($urandom_range(0, 15));
               1:       {b2, b1} = 16'($urandom_range(0, 15));
               default: {b2, b1} = 16'($urandom);
            endcase
         end
         len = instr_length(opc);
         send(OP_WRITE, at, opc);
         if (len >= 2) begin
            send(OP_WRITE, at + 16'd1, b1);
         end
         if (len == 3) begin
            send(OP_WRITE, at + 16'd2, b2);
         end
         if ($urandom_range(0, 7) == 0) begin
            send(OP_READ, ($urandom_range(0, 1) == 0) ? at : 16'($urandom),
                 8'($urandom));
         end
         at = (opc == OPC_JP) ? {b2, b1} : at + 16'(len);
      end
      steps = n;
      if ($urandom_range(0, 7) == 0) begin
         steps = $urandom_range(0, n + 2);
      end
      for (int i = 0; i < steps; i++) begin
         send(OP_EXEC, 16'($urandom), 8'($urandom));
      end
   endtask

   // Stray words of any operation, including the undefined one. HALT bytes
   // are left out so that the run does not stop early.
   task automatic noise_burst();
      logic [15:0] a;
      logic [7:0]  d;
      int          n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         a = ($urandom_range(0, 3) == 0) ? 16'hFF00 + 16'($urandom_range(0, 255))
                                         : 16'($urandom);
         d = 8'($urandom);
         if (d == OPC_HALT) begin
            d = OPC_NOP;
         end
         send(2'($urandom_range(0, 3)), a, d);
      end
   endtask

   task automatic report_mismatch(string msg);
      error_count++;
      $display("mismatch: %s", msg);
   endtask

   // -------------------------------------------------------------------------
   // Request driver. A new word appears at the falling edge after the last
   // one was taken, once the drawn gap has passed.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : req_driver
      req_word_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left      <= gap_left - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            w             = pending_words.pop_front();
            req_bus.op    <= w.op;
            req_bus.addr  <= w.addr;
            req_bus.wdata <= w.wdata;
            req_bus.valid <= 1'b1;
            gap_left      <= draw_wait();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response pacing. After each response is taken, the sink draws a number
   // of cycles to hold ready low. The countdown runs whether or not a
   // response is waiting, so the stalls land on every phase of the core.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : rsp_pacer
      int s;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else begin
         s = rsp_taken ? draw_wait() : stall_left;
         if (s > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= s - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left    <= 0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor. At each rising edge it checks the response word that was
   // taken against the oldest expectation. It then feeds the request word
   // that was taken to the shadow core. The response is handled first
   // because it always belongs to an older request. The watchdog sits here
   // too.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      res_type want;
      bit      moved;
      moved     = 1'b0;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_taken = 1'b1;
            moved     = 1'b1;
            if (expected_rsp_q.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with none expected",
                                         rsp_index));
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_bus.rdata !== want.rdata) begin
                  report_mismatch($sformatf("response %0d rdata %02h, expected %02h",
                                            rsp_index, rsp_bus.rdata, want.rdata));
               end
               if (rsp_bus.pc_out !== want.pc) begin
                  report_mismatch($sformatf("response %0d pc_out %04h, expected %04h",
                                            rsp_index, rsp_bus.pc_out, want.pc));
               end
               if (rsp_bus.acc_out !== want.acc) begin
                  report_mismatch($sformatf("response %0d acc_out %02h, expected %02h",
                                            rsp_index, rsp_bus.acc_out, want.acc));
               end
               if (rsp_bus.status !== want.status) begin
                  report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                            rsp_index, rsp_bus.status, want.status));
               end
            end
            rsp_index++;
         end
         if (req_bus.valid && req_bus.ready) begin
            req_taken = 1'b1;
            moved     = 1'b1;
            expected_rsp_q.push_back(step_core(req_bus.op, req_bus.addr,
                                               req_bus.wdata));
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin : main_seq
      int          seq;
      logic [15:0] at;
      logic [15:0] spot;

      // All inputs have known values before the first edge. The shadow core
      // starts in its reset state.
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op    = OP_WRITE;
      req_bus.addr  = '0;
      req_bus.wdata = '0;
      rsp_bus.ready = 1'b0;
      for (int k = 0; k < MEM_DEPTH; k++) begin
         core_mem[k] = '0;
      end
      foreach (core_gp[k]) begin
         core_gp[k] = '0;
      end
      core_a      = '0;
      core_pc     = '0;
      core_halted = 1'b0;
      sent_count  = 0;
      error_count = 0;
      rsp_index   = 0;
      idle_cycles = 0;
      gap_left    = 0;
      stall_left  = 0;
      req_taken   = 1'b0;
      rsp_taken   = 1'b0;
      calm        = 1'b0;

      // Directed program. Memory reads as zero after reset. The extremes of
      // address and data are written and read back, and the undefined
      // operation is issued. The program then runs a NOP and an unknown
      // opcode. Next comes a jump to the top of memory. There, LD A,n takes
      // its operand from 0xFFFE and leaves PC at 0xFFFF, and a JP at 0xFFFF
      // fetches its operands across the wrap from 0x0000 and 0x0001.
      send(OP_READ,  16'h0000, 8'hFF);
      send(OP_WRITE, 16'hFFFF, 8'hFF);
      send(OP_READ,  16'hFFFF, 8'h00);
      send(OP_WRITE, 16'h0000, 8'h00);
      send(OP_NONE,  16'hFFFF, 8'hFF);
      send(OP_EXEC,  16'h0000, 8'h00);
      send(OP_WRITE, 16'h0001, 8'hFD);
      send(OP_EXEC,  16'hFFFF, 8'hFF);
      send(OP_WRITE, 16'h0002, OPC_JP);
      send(OP_WRITE, 16'h0003, 8'hFD);
      send(OP_WRITE, 16'h0004, 8'hFF);
      send(OP_EXEC,  16'h0000, 8'h00);
      send(OP_WRITE, 16'hFFFD, OPC_LD_A_N);
      send(OP_WRITE, 16'hFFFE, 8'h80);
      send(OP_EXEC,  16'h0000, 8'h00);
      send(OP_WRITE, 16'hFFFF, OPC_JP);
      send(OP_EXEC,  16'h0000, 8'h00);
      send(OP_READ,  16'hFFFF, 8'h00);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Random part. Most sequences are well-formed programs with random
      // content. The rest are stray words. Calm stretches come and go, and
      // now and then the sender drains everything before it goes on.
      seq = 0;
      while (sent_count < ITEM_TARGET) begin
         seq++;
         if ($urandom_range(0, 19) == 0) begin
            calm = !calm;
         end
         if (seq % 40 == 0) begin
            settle();
         end
         if ($urandom_range(0, 5) == 0) begin
            noise_burst();
         end else begin
            run_program();
         end
      end

      // Closing sequence. After HALT, further steps report halted with no
      // change, while memory words still work and report ok.
      calm = 1'b0;
      settle();
      at   = core_pc;
      spot = 16'($urandom);
      send(OP_WRITE, at, OPC_HALT);
      send(OP_EXEC,  16'($urandom), 8'($urandom));
      send(OP_EXEC,  16'($urandom), 8'($urandom));
      send(OP_WRITE, spot, 8'($urandom));
      send(OP_READ,  spot, 8'($urandom));
      send(OP_NONE,  16'($urandom), 8'($urandom));
      send(OP_EXEC,  16'($urandom), 8'($urandom));

      // Let the last responses arrive. The watchdog covers a core that never
      // answers. An extra wait after that catches any surplus response word.
      settle();
      repeat (32) @(posedge clock);

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/t80_pkg.sv
hdl/t80_ifs.sv
hdl/t80_mem.sv
hdl/t80_seq.sv
hdl/tiny_8080_subset_core.sv
sim/tiny_8080_subset_core_test.sv
